>>> rtl/core/flsq_pkg.sv
// Types and codes shared by the flash load/save sequencer.
package flsq_pkg;

    // Top-level sequencer state, reported as the status code
    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_LOADING   = 3'd1,
        ST_LOAD_DONE = 3'd2,
        ST_LOAD_ERR  = 3'd3,
        ST_SAVING    = 3'd4,
        ST_SAVING_NE = 3'd5,
        ST_SAVE_DONE = 3'd6,
        ST_SAVE_ERR  = 3'd7
    } outer_state_t;

    // Step within a load or save. Load uses entry, command and result only:
    // SUB_CMD_A issues the read, SUB_RESULT_A collects it.
    typedef enum logic [3:0] {
        SUB_ENTRY        = 4'd0,
        SUB_CMD_A        = 4'd1,
        SUB_RESULT_A     = 4'd2,
        SUB_ERASE_POLL   = 4'd3,
        SUB_ERASE_STATUS = 4'd4,
        SUB_PROG_WE      = 4'd5,
        SUB_PROG_ISSUE   = 4'd6,
        SUB_PROG_POLL    = 4'd7,
        SUB_PROG_STATUS  = 4'd8
    } sub_state_t;

    // Operation codes carried in tuser
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_LOAD      = 3'd1;
    localparam logic [2:0] OP_SAVE      = 3'd2;
    localparam logic [2:0] OP_SAVE_NE   = 3'd3;
    localparam logic [2:0] OP_RD_STATUS = 3'd4;

    // Command engine states
    localparam logic [2:0] ENG_IDLE        = 3'd0;
    localparam logic [2:0] ENG_READ_DONE   = 3'd1;
    localparam logic [2:0] ENG_WE_DONE     = 3'd2;
    localparam logic [2:0] ENG_ERASE_DONE  = 3'd3;
    localparam logic [2:0] ENG_PROG_DONE   = 3'd4;
    localparam logic [2:0] ENG_STATUS_DONE = 3'd5;

    // Commands issued to the engine
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1;
    localparam logic [2:0] CMD_WE    = 3'd2;
    localparam logic [2:0] CMD_ERASE = 3'd3;
    localparam logic [2:0] CMD_RDSR  = 3'd4;
    localparam logic [2:0] CMD_PROG  = 3'd5;

    // Field widths of the streams
    localparam int CMD_ADDR_W = 25;
    localparam int LEN_W      = 9;
    localparam int BUF_W      = 25;
    localparam int PTR_W      = 26;

    // Result transaction, lowest field in the lowest bits
    typedef struct packed {
        logic [3:0]            pad;
        logic [LEN_W-1:0]      copy_len;
        logic                  fetch_result;
        logic [BUF_W-1:0]      buffer_offset;
        logic [LEN_W-1:0]      cmd_len;
        logic [CMD_ADDR_W-1:0] cmd_addr;
        logic [2:0]            cmd_code;
        logic                  start_refused;
        logic [2:0]            status;
    } result_t;

endpackage

>>> rtl/core/flash_load_save_sequencer.sv
// Flash load/save sequencer: one state-machine step per input transaction.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser operation, tdata tick/start data
//  m_*     | out | m_tvalid/m_tready  | tdata one result per input transaction
//
// Each accepted transaction is decoded combinationally; the state registers and
// the output register both load at the accepting edge, so the result is offered
// on m_* from the next cycle. One transaction per clock is sustained; the path
// is one 27-bit subtract and compare for the chunk length. s_tready drops only
// while a result waits in the output register and m_tready is low. rst_n clears
// the state to idle and empties the output register.
module flash_load_save_sequencer
    import flsq_pkg::*;
#(
    parameter int PAGE_BYTES   = 256,
    parameter int SECTOR_BYTES = 4096,
    parameter int ADDR_BITS    = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[2:0]
    input  logic [2:0]  s_tuser,
    // start_addr[23:0], start_len[48:24], engine_state[51:49], cmd_ok[52],
    // result_ok[53], status_busy[54], zero[55]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], start_refused[3], cmd_code[6:4], cmd_addr[31:7],
    // cmd_len[40:32], buffer_offset[65:41], fetch_result[66],
    // copy_len[75:67], zero[79:76]
    output logic [79:0] m_tdata
);

    localparam int CHUNK_W = $clog2(PAGE_BYTES + 1);
    localparam logic [CHUNK_W-1:0] PAGE_CHUNK = CHUNK_W'(PAGE_BYTES);
    localparam logic [PTR_W-1:0] SECTOR_STEP = PTR_W'(SECTOR_BYTES);
    localparam logic [CMD_ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= CMD_ADDR_W) ?
        {CMD_ADDR_W{1'b1}} : CMD_ADDR_W'((33'd1 << ADDR_BITS) - 33'd1);

    // Input field split
    logic [2:0]  op;
    logic [23:0] in_addr;
    logic [24:0] in_len;
    logic [2:0]  eng;
    logic        cmd_ok;
    logic        res_ok;
    logic        busy;

    assign op      = s_tuser;
    assign in_addr = s_tdata[23:0];
    assign in_len  = s_tdata[48:24];
    assign eng     = s_tdata[51:49];
    assign cmd_ok  = s_tdata[52];
    assign res_ok  = s_tdata[53];
    assign busy    = s_tdata[54];

    // State
    outer_state_t        outer_reg, outer_next;
    sub_state_t          sub_reg, sub_next;
    logic [23:0]         base_reg, base_next;
    logic [PTR_W-1:0]    end_reg, end_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [BUF_W-1:0]    buf_reg, buf_next;
    logic [CHUNK_W-1:0]  last_reg, last_next;
    logic                out_valid_reg;
    result_t             out_reg;
    result_t             res;

    logic                accept;
    logic [PTR_W:0]      left;
    logic [CHUNK_W-1:0]  chunk;
    logic [PTR_W-1:0]    ptr_page;
    logic [PTR_W-1:0]    ptr_sector;
    logic [BUF_W-1:0]    buf_page;
    logic [CMD_ADDR_W-1:0] ptr_addr;
    logic [31:0]         chunk32;
    logic [31:0]         last32;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // Bytes left and next chunk length
    assign left  = {1'b0, end_reg} - {1'b0, ptr_reg};
    assign chunk = (ptr_reg >= end_reg) ? '0 :
                   (left >= (PTR_W+1)'(PAGE_BYTES)) ? PAGE_CHUNK : left[CHUNK_W-1:0];

    assign ptr_page   = ptr_reg + PTR_W'(last_reg);
    assign ptr_sector = ptr_reg + SECTOR_STEP;
    assign buf_page   = buf_reg + BUF_W'(last_reg);
    assign ptr_addr   = ptr_reg[CMD_ADDR_W-1:0] & ADDR_MASK;
    assign chunk32    = 32'(chunk);
    assign last32     = 32'(last_reg);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_reg <= ST_IDLE;
            sub_reg   <= SUB_ENTRY;
            base_reg  <= '0;
            end_reg   <= '0;
            ptr_reg   <= '0;
            buf_reg   <= '0;
            last_reg  <= '0;
        end
        else if (accept)
        begin
            outer_reg <= outer_next;
            sub_reg   <= sub_next;
            base_reg  <= base_next;
            end_reg   <= end_next;
            ptr_reg   <= ptr_next;
            buf_reg   <= buf_next;
            last_reg  <= last_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= res;
        end
    end

    // Next state and result for one transaction
    always_comb
    begin
        outer_next = outer_reg;
        sub_next   = sub_reg;
        base_next  = base_reg;
        end_next   = end_reg;
        ptr_next   = ptr_reg;
        buf_next   = buf_reg;
        last_next  = last_reg;
        res        = '0;

        case (op)
            OP_TICK:
            begin
                if (outer_reg == ST_LOADING)
                begin
                    case (sub_reg)
                        SUB_ENTRY:
                        begin
                            if (eng == ENG_IDLE)
                                sub_next = SUB_CMD_A;
                        end
                        SUB_CMD_A:
                        begin
                            if (eng == ENG_IDLE)
                            begin
                                last_next    = chunk;
                                res.cmd_code = CMD_READ;
                                res.cmd_addr = ptr_addr;
                                res.cmd_len  = chunk32[LEN_W-1:0];
                                if (!cmd_ok)
                                    outer_next = ST_LOAD_ERR;
                                else
                                    sub_next = SUB_RESULT_A;
                            end
                        end
                        SUB_RESULT_A:
                        begin
                            if (eng == ENG_READ_DONE)
                            begin
                                res.fetch_result = 1'b1;
                                if (!res_ok)
                                    outer_next = ST_LOAD_ERR;
                                else
                                begin
                                    res.buffer_offset = buf_reg;
                                    res.copy_len      = last32[LEN_W-1:0];
                                    ptr_next          = ptr_page;
                                    buf_next          = buf_page;
                                    sub_next          = SUB_CMD_A;
                                    if (ptr_page >= end_reg)
                                        outer_next = ST_LOAD_DONE;
                                end
                            end
                        end
                        default:
                        begin
                            sub_next = SUB_ENTRY;
                        end
                    endcase
                end
                else if (outer_reg == ST_SAVING || outer_reg == ST_SAVING_NE)
                begin
                    case (sub_reg)
                        SUB_ENTRY:
                        begin
                            if (eng == ENG_IDLE)
                                sub_next = (outer_reg == ST_SAVING) ? SUB_CMD_A : SUB_PROG_WE;
                        end
                        // write enable ahead of a sector erase
                        SUB_CMD_A:
                        begin
                            if (eng == ENG_IDLE)
                            begin
                                res.cmd_code = CMD_WE;
                                if (!cmd_ok)
                                    outer_next = ST_SAVE_ERR;
                                else
                                    sub_next = SUB_RESULT_A;
                            end
                        end
                        SUB_RESULT_A:
                        begin
                            if (eng == ENG_WE_DONE)
                            begin
                                res.fetch_result = 1'b1;
                                if (!res_ok)
                                    outer_next = ST_SAVE_ERR;
                                else
                                begin
                                    res.cmd_code = CMD_ERASE;
                                    res.cmd_addr = ptr_addr;
                                    if (!cmd_ok)
                                        outer_next = ST_SAVE_ERR;
                                    else
                                        sub_next = SUB_ERASE_POLL;
                                end
                            end
                        end
                        // status read after erase or program
                        SUB_ERASE_POLL, SUB_PROG_POLL:
                        begin
                            if (eng == ENG_IDLE ||
                                (sub_reg == SUB_ERASE_POLL && eng == ENG_ERASE_DONE) ||
                                (sub_reg == SUB_PROG_POLL && eng == ENG_PROG_DONE))
                            begin
                                res.fetch_result = 1'b1;
                                if (!res_ok)
                                    outer_next = ST_SAVE_ERR;
                                else
                                begin
                                    res.cmd_code = CMD_RDSR;
                                    if (!cmd_ok)
                                        outer_next = ST_SAVE_ERR;
                                    else if (sub_reg == SUB_ERASE_POLL)
                                        sub_next = SUB_ERASE_STATUS;
                                    else
                                        sub_next = SUB_PROG_STATUS;
                                end
                            end
                        end
                        SUB_ERASE_STATUS:
                        begin
                            if (eng == ENG_STATUS_DONE)
                            begin
                                res.fetch_result = 1'b1;
                                if (!res_ok)
                                    outer_next = ST_SAVE_ERR;
                                else if (busy)
                                    sub_next = SUB_ERASE_POLL;
                                else if (ptr_sector >= end_reg)
                                begin
                                    // erase covered the range: program from the start
                                    ptr_next = PTR_W'(base_reg);
                                    sub_next = SUB_PROG_WE;
                                end
                                else
                                begin
                                    ptr_next = ptr_sector;
                                    sub_next = SUB_CMD_A;
                                end
                            end
                        end
                        SUB_PROG_WE:
                        begin
                            if (eng == ENG_IDLE)
                            begin
                                res.cmd_code = CMD_WE;
                                res.cmd_addr = ptr_addr;
                                if (!cmd_ok)
                                    outer_next = ST_SAVE_ERR;
                                else
                                    sub_next = SUB_PROG_ISSUE;
                            end
                        end
                        SUB_PROG_ISSUE:
                        begin
                            if (eng == ENG_WE_DONE)
                            begin
                                res.fetch_result = 1'b1;
                                if (!res_ok)
                                    outer_next = ST_SAVE_ERR;
                                else
                                begin
                                    last_next         = chunk;
                                    res.cmd_code      = CMD_PROG;
                                    res.cmd_addr      = ptr_addr;
                                    res.cmd_len       = chunk32[LEN_W-1:0];
                                    res.buffer_offset = buf_reg;
                                    if (!cmd_ok)
                                        outer_next = ST_SAVE_ERR;
                                    else
                                        sub_next = SUB_PROG_POLL;
                                end
                            end
                        end
                        SUB_PROG_STATUS:
                        begin
                            if (eng == ENG_STATUS_DONE)
                            begin
                                res.fetch_result = 1'b1;
                                if (!res_ok)
                                    outer_next = ST_SAVE_ERR;
                                else if (busy)
                                    sub_next = SUB_PROG_POLL;
                                else
                                begin
                                    ptr_next = ptr_page;
                                    buf_next = buf_page;
                                    sub_next = SUB_PROG_WE;
                                    if (ptr_page >= end_reg)
                                        outer_next = ST_SAVE_DONE;
                                end
                            end
                        end
                        default:
                        begin
                            sub_next = SUB_ENTRY;
                        end
                    endcase
                end
                res.status = outer_next;
            end
            OP_LOAD, OP_SAVE, OP_SAVE_NE:
            begin
                if (outer_reg != ST_IDLE)
                    res.start_refused = 1'b1;
                else
                begin
                    base_next = in_addr;
                    ptr_next  = PTR_W'(in_addr);
                    end_next  = PTR_W'(in_addr) + PTR_W'(in_len);
                    buf_next  = '0;
                    sub_next  = SUB_ENTRY;
                    outer_next = (op == OP_LOAD) ? ST_LOADING :
                                 (op == OP_SAVE) ? ST_SAVING : ST_SAVING_NE;
                end
                res.status = outer_next;
            end
            OP_RD_STATUS:
            begin
                // report first, then clear finished states
                res.status = outer_reg;
                if (outer_reg == ST_LOAD_DONE || outer_reg == ST_LOAD_ERR ||
                    outer_reg == ST_SAVE_DONE || outer_reg == ST_SAVE_ERR)
                    outer_next = ST_IDLE;
            end
            default:
            begin
                res.status = outer_reg;
            end
        endcase
    end

    // Checks
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted transaction produced no result");

    a_refused_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.start_refused) |-> (out_reg.status != ST_IDLE))
        else $error("start refused while idle");

    a_copy_only_load: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.copy_len != '0) |->
        (out_reg.fetch_result &&
         (out_reg.status == ST_LOADING || out_reg.status == ST_LOAD_DONE)))
        else $error("copy length outside a load");

    a_len_with_data_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.cmd_len != '0) |->
        (out_reg.cmd_code == CMD_READ || out_reg.cmd_code == CMD_PROG))
        else $error("byte count on a command without data");

endmodule

>>> bench/flash_load_save_sequencer_tb.sv
// Self-checking testbench for the flash load/save sequencer stream block.
module flash_load_save_sequencer_tb
    import flsq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int PAGE_BYTES   = 256;
    localparam int SECTOR_BYTES = 4096;
    localparam int ADDR_BITS    = 24;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 100;
    localparam int MAX_REPORTS  = 10;

    // Opcode outside the defined set, must be ignored
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // Sender idle and receiver stall percentages per phase
    localparam int SRC_PCT [4] = '{0, 86, 0, 27};
    localparam int SINK_PCT [4] = '{0, 0, 86, 27};

    // One input transaction, split into its fields
    typedef struct {
        logic [2:0]  op;
        logic [23:0] addr;
        logic [24:0] len;
        logic [2:0]  eng;
        logic        cok;
        logic        rok;
        logic        busy;
    } item_t;

    // Directed row: stimulus plus an optional typed-in result
    typedef struct {
        item_t   item;
        bit      typed;
        result_t want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [2:0]  s_tuser;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    // Predictor state
    outer_state_t        seq_state = ST_IDLE;
    sub_state_t          step = SUB_ENTRY;
    logic [23:0]         base = '0;
    logic [24:0]         range_len = '0;
    logic [PTR_W-1:0]    addr_ptr = '0;
    logic [BUF_W-1:0]    buf_ptr = '0;
    logic [LEN_W-1:0]    chunk = '0;

    result_t  pending_results [$];
    dir_row_t dir_tab [$];
    int       src_pct = 0;
    int       sink_pct = 0;
    int       work_items = 0;
    int       fail_cnt = 0;
    int       cycle_cnt = 0;
    bit       hold_go = 1'b0;
    bit       hold_on = 1'b0;

    flash_load_save_sequencer #(
        .PAGE_BYTES   (PAGE_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES),
        .ADDR_BITS    (ADDR_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Bytes of the range not yet covered, may go negative
    function automatic longint bytes_left();
        return longint'(base) + longint'(range_len) - longint'(addr_ptr);
    endfunction

    // Length of the next read or program: a page, or what is left
    function automatic logic [LEN_W-1:0] chunk_size();
        longint rem;
        rem = bytes_left();
        if (rem >= PAGE_BYTES)
            return LEN_W'(PAGE_BYTES);
        if (rem < 0)
            return '0;
        return LEN_W'(rem);
    endfunction

    function automatic logic [CMD_ADDR_W-1:0] wrap_addr(input logic [PTR_W-1:0] p);
        return CMD_ADDR_W'(p & ((PTR_W'(1) << ADDR_BITS) - PTR_W'(1)));
    endfunction

    function automatic bit in_progress();
        return seq_state == ST_LOADING || seq_state == ST_SAVING
            || seq_state == ST_SAVING_NE;
    endfunction

    // Advance the sequencer by one transaction and return its result
    function automatic result_t sequencer_step(input item_t it);
        result_t r;
        r = '0;
        case (it.op)
            OP_TICK:
            begin
                if (seq_state == ST_LOADING)
                begin
                    case (step)
                        SUB_ENTRY:
                            if (it.eng == ENG_IDLE)
                                step = SUB_CMD_A;
                        SUB_CMD_A:
                            if (it.eng == ENG_IDLE)
                            begin
                                chunk = chunk_size();
                                r.cmd_code = CMD_READ;
                                r.cmd_addr = wrap_addr(addr_ptr);
                                r.cmd_len = chunk;
                                if (!it.cok)
                                    seq_state = ST_LOAD_ERR;
                                else
                                    step = SUB_RESULT_A;
                            end
                        SUB_RESULT_A:
                            if (it.eng == ENG_READ_DONE)
                            begin
                                r.fetch_result = 1'b1;
                                if (!it.rok)
                                    seq_state = ST_LOAD_ERR;
                                else
                                begin
                                    r.buffer_offset = buf_ptr;
                                    r.copy_len = chunk;
                                    addr_ptr = addr_ptr + PTR_W'(chunk);
                                    buf_ptr = buf_ptr + BUF_W'(chunk);
                                    step = SUB_CMD_A;
                                    if (bytes_left() <= 0)
                                        seq_state = ST_LOAD_DONE;
                                end
                            end
                        default: step = SUB_ENTRY;
                    endcase
                end
                else if (seq_state == ST_SAVING || seq_state == ST_SAVING_NE)
                begin
                    case (step)
                        SUB_ENTRY:
                            if (it.eng == ENG_IDLE)
                                step = (seq_state == ST_SAVING) ? SUB_CMD_A : SUB_PROG_WE;
                        // write enable ahead of a sector erase
                        SUB_CMD_A:
                            if (it.eng == ENG_IDLE)
                            begin
                                r.cmd_code = CMD_WE;
                                if (!it.cok)
                                    seq_state = ST_SAVE_ERR;
                                else
                                    step = SUB_RESULT_A;
                            end
                        SUB_RESULT_A:
                            if (it.eng == ENG_WE_DONE)
                            begin
                                r.fetch_result = 1'b1;
                                if (!it.rok)
                                    seq_state = ST_SAVE_ERR;
                                else
                                begin
                                    r.cmd_code = CMD_ERASE;
                                    r.cmd_addr = wrap_addr(addr_ptr);
                                    if (!it.cok)
                                        seq_state = ST_SAVE_ERR;
                                    else
                                        step = SUB_ERASE_POLL;
                                end
                            end
                        // erase or program finished: ask for the status register
                        SUB_ERASE_POLL, SUB_PROG_POLL:
                            if (it.eng == ENG_IDLE || it.eng == ((step == SUB_ERASE_POLL)
                                ? ENG_ERASE_DONE : ENG_PROG_DONE))
                            begin
                                r.fetch_result = 1'b1;
                                if (!it.rok)
                                    seq_state = ST_SAVE_ERR;
                                else
                                begin
                                    r.cmd_code = CMD_RDSR;
                                    if (!it.cok)
                                        seq_state = ST_SAVE_ERR;
                                    else
                                        step = (step == SUB_ERASE_POLL)
                                            ? SUB_ERASE_STATUS : SUB_PROG_STATUS;
                                end
                            end
                        SUB_ERASE_STATUS:
                            if (it.eng == ENG_STATUS_DONE)
                            begin
                                r.fetch_result = 1'b1;
                                if (!it.rok)
                                    seq_state = ST_SAVE_ERR;
                                else if (it.busy)
                                    step = SUB_ERASE_POLL;
                                else
                                begin
                                    addr_ptr = addr_ptr + PTR_W'(SECTOR_BYTES);
                                    step = SUB_CMD_A;
                                    if (longint'(addr_ptr) >= longint'(base) + longint'(range_len))
                                    begin
                                        addr_ptr = PTR_W'(base);
                                        step = SUB_PROG_WE;
                                    end
                                end
                            end
                        SUB_PROG_WE:
                            if (it.eng == ENG_IDLE)
                            begin
                                r.cmd_code = CMD_WE;
                                r.cmd_addr = wrap_addr(addr_ptr);
                                if (!it.cok)
                                    seq_state = ST_SAVE_ERR;
                                else
                                    step = SUB_PROG_ISSUE;
                            end
                        SUB_PROG_ISSUE:
                            if (it.eng == ENG_WE_DONE)
                            begin
                                r.fetch_result = 1'b1;
                                if (!it.rok)
                                    seq_state = ST_SAVE_ERR;
                                else
                                begin
                                    chunk = chunk_size();
                                    r.cmd_code = CMD_PROG;
                                    r.cmd_addr = wrap_addr(addr_ptr);
                                    r.cmd_len = chunk;
                                    r.buffer_offset = buf_ptr;
                                    if (!it.cok)
                                        seq_state = ST_SAVE_ERR;
                                    else
                                        step = SUB_PROG_POLL;
                                end
                            end
                        SUB_PROG_STATUS:
                            if (it.eng == ENG_STATUS_DONE)
                            begin
                                r.fetch_result = 1'b1;
                                if (!it.rok)
                                    seq_state = ST_SAVE_ERR;
                                else if (it.busy)
                                    step = SUB_PROG_POLL;
                                else
                                begin
                                    addr_ptr = addr_ptr + PTR_W'(chunk);
                                    buf_ptr = buf_ptr + BUF_W'(chunk);
                                    step = SUB_PROG_WE;
                                    if (bytes_left() <= 0)
                                        seq_state = ST_SAVE_DONE;
                                end
                            end
                        default: step = SUB_ENTRY;
                    endcase
                end
                r.status = seq_state;
            end
            OP_LOAD, OP_SAVE, OP_SAVE_NE:
            begin
                if (seq_state != ST_IDLE)
                    r.start_refused = 1'b1;
                else
                begin
                    base = it.addr;
                    addr_ptr = PTR_W'(it.addr);
                    range_len = it.len;
                    buf_ptr = '0;
                    step = SUB_ENTRY;
                    seq_state = (it.op == OP_LOAD) ? ST_LOADING
                              : (it.op == OP_SAVE) ? ST_SAVING : ST_SAVING_NE;
                end
                r.status = seq_state;
            end
            OP_RD_STATUS:
            begin
                // report first, then clear finished states
                r.status = seq_state;
                if (seq_state == ST_LOAD_DONE || seq_state == ST_LOAD_ERR
                    || seq_state == ST_SAVE_DONE || seq_state == ST_SAVE_ERR)
                    seq_state = ST_IDLE;
            end
            default: r.status = seq_state;
        endcase
        return r;
    endfunction

    function automatic result_t mk_result(input logic [2:0] st, input logic refused,
                                          input logic [2:0] cmd,
                                          input logic [CMD_ADDR_W-1:0] addr,
                                          input logic [LEN_W-1:0] len,
                                          input logic [BUF_W-1:0] off,
                                          input logic fetch, input logic [LEN_W-1:0] copy);
        result_t r;
        r = '0;
        r.status = st;
        r.start_refused = refused;
        r.cmd_code = cmd;
        r.cmd_addr = addr;
        r.cmd_len = len;
        r.buffer_offset = off;
        r.fetch_result = fetch;
        r.copy_len = copy;
        return r;
    endfunction

    function automatic string fmt_result(input result_t r);
        return $sformatf({"status=%0d refused=%0d cmd=%0d addr=%h len=%0d",
                          " off=%h fetch=%0d copy=%0d"},
                         r.status, r.start_refused, r.cmd_code, r.cmd_addr, r.cmd_len,
                         r.buffer_offset, r.fetch_result, r.copy_len);
    endfunction

    function automatic item_t rand_item();
        item_t it;
        it.op = 3'($urandom_range(7));
        it.addr = 24'($urandom);
        it.len = 25'($urandom_range(16777216));
        it.eng = 3'($urandom_range(6));
        it.cok = 1'($urandom);
        it.rok = 1'($urandom);
        it.busy = 1'($urandom);
        return it;
    endfunction

    // Engine state that lets the current step move on
    function automatic logic [2:0] wanted_engine();
        case (step)
            SUB_RESULT_A:     return (seq_state == ST_LOADING) ? ENG_READ_DONE : ENG_WE_DONE;
            SUB_ERASE_POLL:   return $urandom_range(1) ? ENG_ERASE_DONE : ENG_IDLE;
            SUB_PROG_POLL:    return $urandom_range(1) ? ENG_PROG_DONE : ENG_IDLE;
            SUB_ERASE_STATUS: return ENG_STATUS_DONE;
            SUB_PROG_STATUS:  return ENG_STATUS_DONE;
            SUB_PROG_ISSUE:   return ENG_WE_DONE;
            default:          return ENG_IDLE;
        endcase
    endfunction

    task automatic add_row(input logic [2:0] op, input logic [23:0] a, input logic [24:0] l,
                           input logic [2:0] eng, input logic cok, input logic rok,
                           input bit typed, input result_t want);
        dir_row_t row;
        row.item = '{op, a, l, eng, cok, rok, 1'b0};
        row.typed = typed;
        row.want = want;
        dir_tab.push_back(row);
    endtask

    // Offer one transaction, wait for acceptance, record what must come out
    task automatic send(input item_t it, input bit typed, input result_t want);
        result_t pred;
        while ($urandom_range(99) < src_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = it.op;
        s_tdata = {1'b0, it.busy, it.rok, it.cok, it.eng, it.len, it.addr};
        do
            @(posedge clk);
        while (!s_tready);
        if (it.op <= OP_RD_STATUS && (it.op != OP_TICK || in_progress()))
            work_items++;
        pred = sequencer_step(it);
        pending_results.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    // One start, mostly well-formed ticks with some noise, then a status read
    task automatic run_sequence();
        item_t it;
        int pick;
        int ticks;
        it = rand_item();
        it.op = 3'(OP_LOAD + 3'($urandom_range(2)));
        pick = $urandom_range(9);
        if (pick == 0)
            it.addr = 24'hFFFFFF - 24'($urandom_range(700));
        else if (pick == 1)
            it.addr = {it.addr[23:12], 12'h000};
        pick = $urandom_range(19);
        if (pick == 0)
            it.len = '0;
        else if (pick == 1)
            it.len = 25'($urandom_range(6000, 4096));
        else
            it.len = 25'($urandom_range(700, 1));
        send(it, 1'b0, '0);
        ticks = 0;
        while (in_progress() && ticks < 400)
        begin
            it = rand_item();
            if ($urandom_range(99) >= 8)
            begin
                it.op = OP_TICK;
                if ($urandom_range(99) < 80)
                    it.eng = wanted_engine();
                it.cok = ($urandom_range(99) < 97);
                it.rok = ($urandom_range(99) < 97);
                it.busy = ($urandom_range(99) < 30);
            end
            send(it, 1'b0, '0);
            ticks++;
        end
        it = rand_item();
        it.op = OP_RD_STATUS;
        send(it, 1'b0, '0);
    endtask

    // Receiver ready, with the long hold-off taking priority
    always @(negedge clk)
        m_tready = !hold_on && ($urandom_range(99) >= sink_pct);

    // Long receiver hold-off so the block backs up into its input
    initial
    begin : hold_off
        wait (hold_go);
        @(posedge clk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result checker: compare each output transaction with the oldest pending result
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata);
            if (pending_results.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS)
                    $display("unexpected result: %s", fmt_result(got));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.start_refused !== want.start_refused
                    || got.cmd_code !== want.cmd_code || got.cmd_addr !== want.cmd_addr
                    || got.cmd_len !== want.cmd_len
                    || got.buffer_offset !== want.buffer_offset
                    || got.fetch_result !== want.fetch_result
                    || got.copy_len !== want.copy_len)
                begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                    begin
                        $display("mismatch expected: %s", fmt_result(want));
                        $display("mismatch actual:   %s", fmt_result(got));
                    end
                end
            end
        end
    end

    // Main stimulus
    initial
    begin : stimulus
        int phase_goal;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = OP_TICK;
        s_tdata = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // after reset, ignored opcode
        add_row(OP_RD_STATUS, 24'h0, 25'h0, ENG_IDLE, 1, 1, 1,
                mk_result(ST_IDLE, 0, CMD_NONE, 0, 0, 0, 0, 0));
        add_row(OP_UNUSED, 24'hFFFFFF, 25'h1FFFFFF, ENG_IDLE, 1, 1, 1,
                mk_result(ST_IDLE, 0, CMD_NONE, 0, 0, 0, 0, 0));
        // zero-length load at the top address, refused start, engine busy
        add_row(OP_LOAD, 24'hFFFFFF, 25'h0, ENG_IDLE, 1, 1, 1,
                mk_result(ST_LOADING, 0, CMD_NONE, 0, 0, 0, 0, 0));
        add_row(OP_TICK, 24'h0, 25'h0, ENG_IDLE, 1, 1, 1,
                mk_result(ST_LOADING, 0, CMD_NONE, 0, 0, 0, 0, 0));
        add_row(OP_TICK, 24'h0, 25'h0, ENG_IDLE, 1, 1, 1,
                mk_result(ST_LOADING, 0, CMD_READ, 25'hFFFFFF, 0, 0, 0, 0));
        add_row(OP_SAVE, 24'h0, 25'h100, ENG_IDLE, 1, 1, 1,
                mk_result(ST_LOADING, 1, CMD_NONE, 0, 0, 0, 0, 0));
        add_row(OP_TICK, 24'h0, 25'h0, 3'd6, 1, 1, 1,
                mk_result(ST_LOADING, 0, CMD_NONE, 0, 0, 0, 0, 0));
        add_row(OP_TICK, 24'h0, 25'h0, ENG_READ_DONE, 1, 1, 1,
                mk_result(ST_LOAD_DONE, 0, CMD_NONE, 0, 0, 0, 1, 0));
        add_row(OP_RD_STATUS, 24'h0, 25'h0, ENG_IDLE, 1, 1, 1,
                mk_result(ST_LOAD_DONE, 0, CMD_NONE, 0, 0, 0, 0, 0));
        // maximum length from the top address: second read wraps, command refused
        add_row(OP_LOAD, 24'hFFFFFF, 25'h1000000, ENG_IDLE, 1, 1, 0, '0);
        add_row(OP_TICK, 24'h0, 25'h0, ENG_IDLE, 1, 1, 0, '0);
        add_row(OP_TICK, 24'h0, 25'h0, ENG_IDLE, 1, 1, 0, '0);
        add_row(OP_TICK, 24'h0, 25'h0, ENG_READ_DONE, 1, 1, 0, '0);
        add_row(OP_TICK, 24'h0, 25'h0, ENG_IDLE, 0, 1, 1,
                mk_result(ST_LOAD_ERR, 0, CMD_READ, 25'h0000FF, 256, 0, 0, 0));
        add_row(OP_RD_STATUS, 24'h0, 25'h0, ENG_IDLE, 1, 1, 1,
                mk_result(ST_LOAD_ERR, 0, CMD_NONE, 0, 0, 0, 0, 0));
        // zero-length save, result fetch fails after erase
        add_row(OP_SAVE, 24'h0, 25'h0, ENG_IDLE, 1, 1, 0, '0);
        add_row(OP_TICK, 24'h0, 25'h0, ENG_IDLE, 1, 1, 0, '0);
        add_row(OP_TICK, 24'h0, 25'h0, ENG_IDLE, 1, 1, 0, '0);
        add_row(OP_TICK, 24'h0, 25'h0, ENG_WE_DONE, 1, 1, 0, '0);
        add_row(OP_TICK, 24'h0, 25'h0, ENG_ERASE_DONE, 1, 0, 1,
                mk_result(ST_SAVE_ERR, 0, CMD_NONE, 0, 0, 0, 1, 0));
        add_row(OP_RD_STATUS, 24'h0, 25'h0, ENG_IDLE, 1, 1, 1,
                mk_result(ST_SAVE_ERR, 0, CMD_NONE, 0, 0, 0, 0, 0));
        // save without erase, write enable refused
        add_row(OP_SAVE_NE, 24'h123456, 25'h1000000, ENG_IDLE, 1, 1, 0, '0);
        add_row(OP_TICK, 24'h0, 25'h0, ENG_IDLE, 1, 1, 0, '0);
        add_row(OP_TICK, 24'h0, 25'h0, ENG_IDLE, 0, 1, 1,
                mk_result(ST_SAVE_ERR, 0, CMD_WE, 25'h123456, 0, 0, 0, 0));
        add_row(OP_RD_STATUS, 24'h0, 25'h0, ENG_IDLE, 1, 1, 1,
                mk_result(ST_SAVE_ERR, 0, CMD_NONE, 0, 0, 0, 0, 0));

        foreach (dir_tab[i])
            send(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

        // random sequences under each idling mix
        for (int phase = 0; phase < 4; phase++)
        begin
            src_pct = SRC_PCT[phase];
            sink_pct = SINK_PCT[phase];
            if (phase == 0)
                hold_go = 1'b1;
            phase_goal = work_items + PHASE_ITEMS;
            while (work_items < phase_goal)
                run_sequence();
        end
        s_tvalid = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
